FILE: hw/rtl/tmhq_pkg.sv
// Shared types, constants and codes for the timer min-heap queue.
package tmhq_pkg;

	localparam int HEAP_DEPTH_DEF = 64;
	localparam int ID_COUNT_DEF = 256;
	localparam int TIME_BITS_DEF = 32;
	localparam int ID_W = 8;
	localparam int EXP_W = 32;
	localparam int STATUS_W = 3;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_FULL = 3'd1,
		ST_FIRED = 3'd2,
		ST_DISCARD = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	// Command handed from the front end to the heap engine.
	typedef struct packed {
		op_t op;
		logic [ID_W-1:0] id;
		logic [EXP_W-1:0] expire;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_UP_WR,
		S_POP_RD,
		S_POP_HEAD,
		S_TAIL_RD,
		S_TAIL_LD,
		S_DN_RD,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_SEL,
		S_DN_WR,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_POP_EMIT
	} eng_state_t;

endpackage

FILE: hw/rtl/timer_min_heap_queue.sv
// Top level of the timer min-heap queue.
//  channel | direction | handshake          | fields
//  in      | input     | in_valid/in_stall  | operation, timer_id, expire_time
//  out     | output    | out_valid/out_stall| status, out_id, out_expire, last
// A transaction is registered in the queue before it reaches the engine; cancel, full add
// and empty tick finish in the idle state, and an add reads and compares one parent per
// sift-up level, then writes. A tick reads the root, then per popped entry moves the tail
// to the root, sifts it down and reads the new root; the pop that empties the heap emits at once.
// The engine runs one command at a time; a two-entry queue in front keeps accepting.
// Reset clears the count and cancel flags; heap memory needs no clearing.
// A stalled result holds the engine, and a full queue stalls the input.
module timer_min_heap_queue #(
	parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF,
	parameter int ID_COUNT = tmhq_pkg::ID_COUNT_DEF,
	parameter int TIME_BITS = tmhq_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic [tmhq_pkg::ID_W-1:0] timer_id,
	input  logic [tmhq_pkg::EXP_W-1:0] expire_time,
	output logic out_valid,
	input  logic out_stall,
	output logic [tmhq_pkg::STATUS_W-1:0] status,
	output logic [tmhq_pkg::ID_W-1:0] out_id,
	output logic [tmhq_pkg::EXP_W-1:0] out_expire,
	output logic last
);
	tmhq_pkg::cmd_t cmd;
	logic cmd_valid, cmd_take;

	tmhq_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .timer_id, .expire_time,
		.cmd_valid, .cmd_take, .cmd
	);

	tmhq_engine #(
		.HEAP_DEPTH(HEAP_DEPTH), .ID_COUNT(ID_COUNT), .TIME_BITS(TIME_BITS)
	) u_engine (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .status, .out_id, .out_expire, .last
	);
endmodule

FILE: hw/rtl/tmhq_front.sv
// Front end: accepts transactions, drops unused codes, queues heap commands.
module tmhq_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic [tmhq_pkg::ID_W-1:0] timer_id,
	input  logic [tmhq_pkg::EXP_W-1:0] expire_time,
	output logic cmd_valid,
	input  logic cmd_take,
	output tmhq_pkg::cmd_t cmd
);
	tmhq_pkg::cmd_t fifo_q [tmhq_pkg::FIFO_DEPTH];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] cnt_q;
	logic acc, is_cmd, push, pop;

	assign in_stall = (cnt_q == 2'(tmhq_pkg::FIFO_DEPTH));
	assign acc = in_valid && !in_stall;
	// Cancels go through the queue too, so flag updates keep command order.
	assign is_cmd = (operation != tmhq_pkg::OP_NONE);
	assign push = acc && is_cmd;
	assign pop = cmd_valid && cmd_take;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	// Hold queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].op <= tmhq_pkg::op_t'(operation);
			fifo_q[wr_ptr_q].id <= timer_id;
			fifo_q[wr_ptr_q].expire <= expire_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(tmhq_pkg::FIFO_DEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count slip");
endmodule

FILE: hw/rtl/tmhq_engine.sv
// Heap engine: cancel flags, sift-up insert and tick pop runs with sift-down over a RAM.
module tmhq_engine #(
	parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF,
	parameter int ID_COUNT = tmhq_pkg::ID_COUNT_DEF,
	parameter int TIME_BITS = tmhq_pkg::TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_take,
	input  tmhq_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_stall,
	output logic [tmhq_pkg::STATUS_W-1:0] status,
	output logic [tmhq_pkg::ID_W-1:0] out_id,
	output logic [tmhq_pkg::EXP_W-1:0] out_expire,
	output logic last
);
	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int PW = AW + 1;
	localparam int EW = TIME_BITS + tmhq_pkg::ID_W;
	localparam int ID_N = 1 << tmhq_pkg::ID_W;
	localparam int FN = (ID_COUNT < ID_N) ? ID_COUNT : ID_N;
	localparam int FW = $clog2(FN);

	// Entry memory: {expire, id}, one write and one read port, registered read.
	logic [EW-1:0] mem [HEAP_DEPTH];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic we, re;

	tmhq_pkg::eng_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q, par_q, cidx_q;
	logic [TIME_BITS-1:0] key_q, due_q;
	logic [tmhq_pkg::ID_W-1:0] kid_q;
	logic [EW-1:0] ca_q, top_q;
	logic first_q, flag_q, lastp_q;
	logic [FN-1:0] flags_q;
	logic [FW-1:0] mod_tab [ID_N];

	logic out_full_q;
	logic [tmhq_pkg::STATUS_W-1:0] st_q;
	logic [tmhq_pkg::ID_W-1:0] oid_q;
	logic [tmhq_pkg::EXP_W-1:0] oex_q;
	logic last_q;

	logic take, full, slot_free;
	logic out_load, ld_last;
	logic [tmhq_pkg::STATUS_W-1:0] ld_st;
	logic [tmhq_pkg::ID_W-1:0] ld_id;
	logic [tmhq_pkg::EXP_W-1:0] ld_ex;
	logic [TIME_BITS-1:0] r_ex, ca_ex, top_ex;
	logic [tmhq_pkg::ID_W-1:0] r_id, top_id;
	logic [AW-1:0] par;
	logic [PW-1:0] lchild, rchild, cnt_w;
	logic lc_ok, rc_ok;

	// Map each id to its flag slot; the table is fixed at elaboration.
	for (genvar g = 0; g < ID_N; g++) begin : g_mod
		assign mod_tab[g] = FW'(g % ID_COUNT);
	end

	assign r_ex = rdata_q[EW-1:tmhq_pkg::ID_W];
	assign r_id = rdata_q[tmhq_pkg::ID_W-1:0];
	assign ca_ex = ca_q[EW-1:tmhq_pkg::ID_W];
	assign top_ex = top_q[EW-1:tmhq_pkg::ID_W];
	assign top_id = top_q[tmhq_pkg::ID_W-1:0];
	assign par = (pos_q - AW'(1)) >> 1;
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + PW'(1);
	assign cnt_w = PW'(count_q);
	assign lc_ok = (lchild < cnt_w);
	assign rc_ok = (rchild < cnt_w);
	assign full = (count_q == CW'(HEAP_DEPTH));
	assign slot_free = !out_full_q || !out_stall;
	assign take = (state_q == tmhq_pkg::S_IDLE) && cmd_valid && slot_free;

	assign out_valid = out_full_q;
	assign status = st_q;
	assign out_id = oid_q;
	assign out_expire = oex_q;
	assign last = last_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmhq_pkg::S_IDLE: begin
				if (take) begin
					if (cmd.op == tmhq_pkg::OP_ADD && !full) begin
						state_d = (count_q == '0) ? tmhq_pkg::S_UP_WR : tmhq_pkg::S_UP_RD;
					end else if (cmd.op == tmhq_pkg::OP_TICK && count_q != '0) begin
						state_d = tmhq_pkg::S_POP_RD;
					end
				end
			end
			tmhq_pkg::S_UP_RD: state_d = tmhq_pkg::S_UP_CMP;
			tmhq_pkg::S_UP_CMP: begin
				if (r_ex <= key_q || par_q == '0) state_d = tmhq_pkg::S_UP_WR;
				else state_d = tmhq_pkg::S_UP_RD;
			end
			tmhq_pkg::S_UP_WR: state_d = tmhq_pkg::S_IDLE;
			tmhq_pkg::S_POP_RD: state_d = tmhq_pkg::S_POP_HEAD;
			tmhq_pkg::S_POP_HEAD: begin
				if (count_q == CW'(1)) state_d = tmhq_pkg::S_POP_EMIT;
				else state_d = tmhq_pkg::S_TAIL_RD;
			end
			tmhq_pkg::S_TAIL_RD: state_d = tmhq_pkg::S_TAIL_LD;
			tmhq_pkg::S_TAIL_LD: state_d = tmhq_pkg::S_DN_RD;
			tmhq_pkg::S_DN_RD: state_d = lc_ok ? tmhq_pkg::S_DN_LEFT : tmhq_pkg::S_DN_WR;
			tmhq_pkg::S_DN_LEFT: state_d = rc_ok ? tmhq_pkg::S_DN_RIGHT : tmhq_pkg::S_DN_SEL;
			tmhq_pkg::S_DN_RIGHT: state_d = tmhq_pkg::S_DN_SEL;
			tmhq_pkg::S_DN_SEL: begin
				if (ca_ex < key_q) state_d = tmhq_pkg::S_DN_RD;
				else state_d = tmhq_pkg::S_DN_WR;
			end
			tmhq_pkg::S_DN_WR: state_d = tmhq_pkg::S_NEXT_RD;
			tmhq_pkg::S_NEXT_RD: state_d = tmhq_pkg::S_NEXT_CHK;
			tmhq_pkg::S_NEXT_CHK: state_d = tmhq_pkg::S_POP_EMIT;
			tmhq_pkg::S_POP_EMIT: begin
				if (slot_free) state_d = lastp_q ? tmhq_pkg::S_IDLE : tmhq_pkg::S_POP_HEAD;
			end
			default: state_d = tmhq_pkg::S_IDLE;
		endcase
	end

	// Memory port and result control.
	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = {key_q, kid_q};
		cmd_take = 1'b0;
		out_load = 1'b0;
		ld_st = tmhq_pkg::ST_ADDED;
		ld_id = '0;
		ld_ex = '0;
		ld_last = 1'b1;
		unique case (state_q)
			tmhq_pkg::S_IDLE: begin
				cmd_take = take;
				if (take && cmd.op == tmhq_pkg::OP_ADD) begin
					out_load = 1'b1;
					ld_st = full ? tmhq_pkg::ST_FULL : tmhq_pkg::ST_ADDED;
					ld_id = cmd.id;
					ld_ex = tmhq_pkg::EXP_W'(TIME_BITS'(cmd.expire));
				end else if (take && cmd.op == tmhq_pkg::OP_TICK && count_q == '0) begin
					out_load = 1'b1;
					ld_st = tmhq_pkg::ST_EMPTY;
				end
			end
			tmhq_pkg::S_UP_RD: begin
				re = 1'b1;
				raddr = par;
			end
			tmhq_pkg::S_UP_CMP: begin
				if (r_ex > key_q) begin
					we = 1'b1;
					waddr = pos_q;
					wdata = rdata_q;
				end
			end
			tmhq_pkg::S_UP_WR, tmhq_pkg::S_DN_WR: begin
				we = 1'b1;
				waddr = pos_q;
			end
			tmhq_pkg::S_POP_RD, tmhq_pkg::S_NEXT_RD: begin
				re = 1'b1;
				raddr = '0;
			end
			tmhq_pkg::S_TAIL_RD: begin
				re = 1'b1;
				raddr = AW'(count_q);
			end
			tmhq_pkg::S_DN_RD: begin
				re = lc_ok;
				raddr = AW'(lchild);
			end
			tmhq_pkg::S_DN_LEFT: begin
				re = rc_ok;
				raddr = AW'(rchild);
			end
			tmhq_pkg::S_DN_SEL: begin
				if (ca_ex < key_q) begin
					we = 1'b1;
					waddr = pos_q;
					wdata = ca_q;
				end
			end
			tmhq_pkg::S_POP_EMIT: begin
				out_load = slot_free;
				ld_st = flag_q ? tmhq_pkg::ST_DISCARD : tmhq_pkg::ST_FIRED;
				ld_id = top_id;
				ld_ex = tmhq_pkg::EXP_W'(top_ex);
				ld_last = lastp_q;
			end
			default: ;
		endcase
	end

	// State, count, cancel flags and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmhq_pkg::S_IDLE;
			count_q <= '0;
			flags_q <= '0;
			out_full_q <= 1'b0;
			st_q <= '0;
			oid_q <= '0;
			oex_q <= '0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_full_q <= out_load || (out_full_q && out_stall);
			if (out_load) begin
				st_q <= ld_st;
				oid_q <= ld_id;
				oex_q <= ld_ex;
				last_q <= ld_last;
			end
			if (take && cmd.op == tmhq_pkg::OP_ADD && !full) begin
				count_q <= count_q + CW'(1);
				flags_q[mod_tab[cmd.id]] <= 1'b0;
			end else if (take && cmd.op == tmhq_pkg::OP_CANCEL) begin
				flags_q[mod_tab[cmd.id]] <= 1'b1;
			end else if (state_q == tmhq_pkg::S_POP_HEAD) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			tmhq_pkg::S_IDLE: begin
				if (take) begin
					key_q <= TIME_BITS'(cmd.expire);
					kid_q <= cmd.id;
					pos_q <= AW'(count_q);
					first_q <= 1'b1;
				end
			end
			tmhq_pkg::S_UP_RD: par_q <= par;
			tmhq_pkg::S_UP_CMP: if (r_ex > key_q) pos_q <= par_q;
			// Latch the root being popped and its cancel flag.
			tmhq_pkg::S_POP_HEAD: begin
				top_q <= rdata_q;
				flag_q <= flags_q[mod_tab[r_id]];
				lastp_q <= (count_q == CW'(1));
				if (first_q) begin
					due_q <= r_ex;
					first_q <= 1'b0;
				end
			end
			// Load the moved tail entry as the sift-down key.
			tmhq_pkg::S_TAIL_LD: begin
				key_q <= r_ex;
				kid_q <= r_id;
				pos_q <= '0;
			end
			tmhq_pkg::S_DN_LEFT: begin
				ca_q <= rdata_q;
				cidx_q <= AW'(lchild);
			end
			// Take the right child only when it is strictly smaller.
			tmhq_pkg::S_DN_RIGHT: begin
				if (r_ex < ca_ex) begin
					ca_q <= rdata_q;
					cidx_q <= AW'(rchild);
				end
			end
			tmhq_pkg::S_DN_SEL: if (ca_ex < key_q) pos_q <= cidx_q;
			// End the run when the new root is later than the due time.
			tmhq_pkg::S_NEXT_CHK: lastp_q <= (r_ex > due_q);
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(HEAP_DEPTH))
		else $error("heap count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && out_stall) |=> out_full_q && $stable(oid_q) && $stable(st_q))
		else $error("held result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == tmhq_pkg::S_IDLE)
		else $error("command taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n) out_load |-> slot_free)
		else $error("result overwritten");
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the timer min-heap queue.
module testbench;

	localparam int DEPTH = tmhq_pkg::HEAP_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct {
		logic [2:0] status;
		logic [7:0] id;
		logic [31:0] expire;
		logic last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = tmhq_pkg::OP_NONE;
	logic [7:0] timer_id = '0;
	logic [31:0] expire_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] out_id;
	logic [31:0] out_expire;
	logic last;

	// Predictor state: shadow heap and cancel flags
	logic [31:0] shadow_expire [DEPTH];
	logic [7:0] shadow_id [DEPTH];
	int shadow_count = 0;
	bit cancel_flag [256];
	timer_result_t pending_results [$];

	int error_count = 0;
	int result_count = 0;
	int sent_count = 0;
	int fired_count = 0;
	int full_count = 0;
	longint cycle_count = 0;
	bit hold_off = 1'b0;
	int stall_pct = 20;

	timer_min_heap_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .timer_id(timer_id), .expire_time(expire_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_id(out_id), .out_expire(out_expire), .last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void push_result(logic [2:0] st, logic [7:0] id, logic [31:0] ex,
		logic lst);
		timer_result_t r;
		r.status = st;
		r.id = id;
		r.expire = ex;
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void heap_sift_down();
		int pos;
		int c;
		logic [31:0] ex;
		logic [7:0] id;
		pos = 0;
		ex = shadow_expire[0];
		id = shadow_id[0];
		while (2 * pos + 1 < shadow_count) begin
			c = 2 * pos + 1;
			if (c + 1 < shadow_count && shadow_expire[c + 1] < shadow_expire[c])
				c++;
			if (shadow_expire[c] >= ex)
				break;
			shadow_expire[pos] = shadow_expire[c];
			shadow_id[pos] = shadow_id[c];
			pos = c;
		end
		shadow_expire[pos] = ex;
		shadow_id[pos] = id;
	endfunction

	// Work out the results of one accepted transaction
	function automatic void predict_timer_op(logic [1:0] op, logic [7:0] id, logic [31:0] ex);
		int pos;
		int par;
		int n;
		logic [31:0] due;
		logic [2:0] st;
		case (op)
			tmhq_pkg::OP_ADD: begin
				if (shadow_count >= DEPTH) begin
					push_result(tmhq_pkg::ST_FULL, id, ex, 1'b1);
				end else begin
					cancel_flag[id] = 1'b0;
					pos = shadow_count;
					shadow_count++;
					while (pos > 0) begin
						par = (pos - 1) / 2;
						if (shadow_expire[par] <= ex)
							break;
						shadow_expire[pos] = shadow_expire[par];
						shadow_id[pos] = shadow_id[par];
						pos = par;
					end
					shadow_expire[pos] = ex;
					shadow_id[pos] = id;
					push_result(tmhq_pkg::ST_ADDED, id, ex, 1'b1);
				end
			end
			tmhq_pkg::OP_CANCEL: cancel_flag[id] = 1'b1;
			tmhq_pkg::OP_TICK: begin
				if (shadow_count == 0) begin
					push_result(tmhq_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					due = shadow_expire[0];
					n = 0;
					while (shadow_count > 0 && shadow_expire[0] <= due && n < DEPTH) begin
						st = cancel_flag[shadow_id[0]] ? tmhq_pkg::ST_DISCARD
							: tmhq_pkg::ST_FIRED;
						push_result(st, shadow_id[0], shadow_expire[0], 1'b0);
						n++;
						shadow_count--;
						shadow_expire[0] = shadow_expire[shadow_count];
						shadow_id[0] = shadow_id[shadow_count];
						heap_sift_down();
					end
					pending_results[$].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		timer_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d id %0d", status, out_id);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status == tmhq_pkg::ST_FIRED)
					fired_count++;
				if (status == tmhq_pkg::ST_FULL)
					full_count++;
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					error_count++;
				end
				if (out_id !== exp_r.id) begin
					$error("out_id: expected %0d, got %0d", exp_r.id, out_id);
					error_count++;
				end
				if (out_expire !== exp_r.expire) begin
					$error("out_expire: expected %0h, got %0h", exp_r.expire, out_expire);
					error_count++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0b, got %0b", exp_r.last, last);
					error_count++;
				end
			end
		end
	end

	// Stall the output on a random pattern, or hold it off entirely
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Send one transaction and wait for it to be accepted
	task automatic send_item(logic [1:0] op, logic [7:0] id, logic [31:0] ex);
		operation <= op;
		timer_id <= id;
		expire_time <= ex;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_timer_op(op, id, ex);
		sent_count++;
		// idle gap between bursts
		if ($urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_expire();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: return 32'hFFFF_FFF0 | $urandom_range(15);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed();
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		send_item(tmhq_pkg::OP_CANCEL, 8'hFF, 32'd0);
		send_item(tmhq_pkg::OP_ADD, 8'hFF, 32'hFFFF_FFFF);
		send_item(tmhq_pkg::OP_ADD, 8'h00, 32'd0);
		send_item(tmhq_pkg::OP_ADD, 8'h55, 32'd0);
		send_item(tmhq_pkg::OP_ADD, 8'hAA, 32'd5);
		send_item(tmhq_pkg::OP_CANCEL, 8'h55, 32'hFFFF_FFFF);
		send_item(tmhq_pkg::OP_NONE, 8'h12, 32'h1234_5678);
		send_item(tmhq_pkg::OP_TICK, 8'hFF, 32'hFFFF_FFFF);
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		send_item(tmhq_pkg::OP_ADD, 8'h55, 32'd7);
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		drain_results();
	endtask

	// Fill past capacity so full drops occur, then pop in batches
	task automatic test_full_heap();
		for (int i = 0; i < DEPTH + 3; i++)
			send_item(tmhq_pkg::OP_ADD, i[7:0], $urandom_range(20));
		while (shadow_count > 0)
			send_item(tmhq_pkg::OP_TICK, 8'($urandom()), $urandom());
		drain_results();
	endtask

	// Receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_item(tmhq_pkg::OP_ADD, 8'($urandom()), rand_expire());
		join
		send_item(tmhq_pkg::OP_TICK, 8'd0, 32'd0);
		drain_results();
	endtask

	task automatic test_random(int count, int pct);
		logic [1:0] op;
		logic [7:0] id;
		stall_pct = pct;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: op = tmhq_pkg::OP_ADD;
				5, 6: op = tmhq_pkg::OP_CANCEL;
				7, 8: op = tmhq_pkg::OP_TICK;
				default: op = tmhq_pkg::OP_NONE;
			endcase
			id = ($urandom_range(1)) ? 8'($urandom_range(15)) : 8'($urandom());
			send_item(op, id, rand_expire());
		end
		drain_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_heap();
		test_backpressure();
		test_random(90, 0);
		test_random(90, 50);
		test_random(75, 20);
		$display("Sent %0d transactions, checked %0d results (%0d fired, %0d full drops).",
			sent_count, result_count, fired_count, full_count);
		$display("Covered empty ticks, cancels, equal-expiry groups, overflow and backpressure.");
		if (error_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tmhq_pkg.sv
hw/rtl/tmhq_front.sv
hw/rtl/tmhq_engine.sv
hw/rtl/timer_min_heap_queue.sv
tb/sv/testbench.sv
